>>> hw/rtl/qft_pkg.sv
`default_nettype none
package qft_pkg;

  localparam int TABLE_ENTRIES = 64;
  localparam int ADDRESS_BITS  = 32;
  localparam int PORT_BITS     = 8;

  // Widths of the channel fields.
  localparam int OP_W        = 2;
  localparam int IN_ADDR_W   = 32;
  localparam int QOS_W       = 16;
  localparam int IN_PORT_W   = 8;
  localparam int STATUS_W    = 2;

  // Only the low bits of address and port take part in the table.
  localparam int KEY_W  = (ADDRESS_BITS < IN_ADDR_W) ? ADDRESS_BITS : IN_ADDR_W;
  localparam int PORT_W = (PORT_BITS < IN_PORT_W) ? PORT_BITS : IN_PORT_W;
  localparam int IDX_W  = $clog2(TABLE_ENTRIES);

  typedef enum logic [OP_W-1:0] {
    OP_LOOKUP = 2'd0,
    OP_INSERT = 2'd1,
    OP_REMOVE = 2'd2,
    OP_CLEAR  = 2'd3
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_FULL      = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_COMMIT
  } state_t;

  typedef struct packed {
    logic [KEY_W-1:0] addr;
    logic [QOS_W-1:0] qos;
  } query_t;

  // Partial search result handed from one cell to the next.
  typedef struct packed {
    logic              exact_hit;
    logic [IDX_W-1:0]  exact_idx;
    logic [PORT_W-1:0] exact_port;
    logic              fb_hit;
    logic [QOS_W-1:0]  fb_qos;
    logic [PORT_W-1:0] fb_port;
    logic              free_hit;
    logic [IDX_W-1:0]  free_idx;
  } carry_t;

  typedef struct packed {
    logic              set_en;
    logic              clr_en;
    logic              clr_all;
    logic [IDX_W-1:0]  idx;
    logic [KEY_W-1:0]  addr;
    logic [QOS_W-1:0]  qos;
    logic [PORT_W-1:0] port;
  } wr_cmd_t;

endpackage
`default_nettype wire

>>> hw/rtl/qos_forwarding_table_core.sv
`default_nettype none
// Forwarding table keyed by (address, QoS class); a lookup of class 0 that
// misses falls back to the lowest class stored for the address. Each slot
// lives in a cell of a chain; a search result ripples through the chain one
// cell per clock. Every operation (lookup, insert, remove, clear) is accepted
// in S_IDLE, crosses the chain in S_SCAN and commits its write and result beat
// in S_COMMIT; no new beat is taken before that commit. The result beat sits
// in an output register, so a new input beat is taken while it still waits.
// Every input beat gives exactly one result beat.
module qos_forwarding_table_core (
  input  wire                            clk,
  input  wire                            rst_n,
  input  wire                            in_valid,
  output logic                           in_ready,
  input  wire  [qft_pkg::OP_W-1:0]       in_operation,
  input  wire  [qft_pkg::IN_ADDR_W-1:0]  in_dst_address,
  input  wire  [qft_pkg::QOS_W-1:0]      in_qos_class,
  input  wire  [qft_pkg::IN_PORT_W-1:0]  in_port_in,
  output logic                           out_valid,
  input  wire                            out_ready,
  output logic                           out_hit,
  output logic [qft_pkg::IN_PORT_W-1:0]  out_port_out,
  output logic [qft_pkg::QOS_W-1:0]      out_matched_qos,
  output logic [qft_pkg::STATUS_W-1:0]   out_status
);

  qft_pkg::state_t              state_r, state_nxt;
  logic [qft_pkg::IDX_W-1:0]    cnt_r, cnt_nxt;
  qft_pkg::op_t                 op_r;
  qft_pkg::query_t              query_r;
  logic [qft_pkg::PORT_W-1:0]   port_r;

  logic                         out_valid_r, out_valid_nxt;
  logic                         out_hit_r, out_hit_nxt;
  logic [qft_pkg::PORT_W-1:0]   out_port_r, out_port_nxt;
  logic [qft_pkg::QOS_W-1:0]    out_qos_r, out_qos_nxt;
  qft_pkg::status_t             out_status_r, out_status_nxt;

  qft_pkg::carry_t              chain [qft_pkg::TABLE_ENTRIES];
  qft_pkg::carry_t              last;
  qft_pkg::wr_cmd_t             wr;
  logic                         in_acc;
  logic                         commit_go;
  logic                         res_hit;
  logic [qft_pkg::PORT_W-1:0]   res_port;
  logic [qft_pkg::QOS_W-1:0]    res_qos;
  qft_pkg::status_t             res_status;

  assign in_acc    = in_valid && in_ready;
  assign commit_go = (state_r == qft_pkg::S_COMMIT) && (!out_valid_r || out_ready);
  assign last      = chain[qft_pkg::TABLE_ENTRIES-1];

  genvar g;
  generate
    for (g = 0; g < qft_pkg::TABLE_ENTRIES; g++) begin : g_cell
      qft_pkg::carry_t cin;
      if (g == 0) begin : g_head
        assign cin = '0;
      end else begin : g_link
        assign cin = chain[g-1];
      end
      qft_cell u_cell (
        .clk      (clk),
        .rst_n    (rst_n),
        .cell_idx (qft_pkg::IDX_W'(g)),
        .query    (query_r),
        .wr       (wr),
        .carry_in (cin),
        .carry_out(chain[g])
      );
    end
  endgenerate

  // Next state.
  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    unique case (state_r)
      qft_pkg::S_IDLE: begin
        if (in_acc) begin
          state_nxt = qft_pkg::S_SCAN;
          cnt_nxt   = '0;
        end
      end
      qft_pkg::S_SCAN: begin
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == qft_pkg::IDX_W'(qft_pkg::TABLE_ENTRIES - 1)) begin
          state_nxt = qft_pkg::S_COMMIT;
        end
      end
      qft_pkg::S_COMMIT: begin
        if (commit_go) begin
          state_nxt = qft_pkg::S_IDLE;
        end
      end
      default: state_nxt = qft_pkg::S_IDLE;
    endcase
  end

  // Outputs of the state machine: result fields and the table write.
  always_comb begin
    res_hit    = 1'b0;
    res_port   = '0;
    res_qos    = '0;
    res_status = qft_pkg::ST_OK;
    wr         = '0;
    wr.addr    = query_r.addr;
    wr.qos     = query_r.qos;
    wr.port    = port_r;
    unique case (op_r)
      qft_pkg::OP_LOOKUP: begin
        if (last.exact_hit) begin
          res_hit  = 1'b1;
          res_port = last.exact_port;
          res_qos  = query_r.qos;
        end else if ((query_r.qos == '0) && last.fb_hit) begin
          res_hit  = 1'b1;
          res_port = last.fb_port;
          res_qos  = last.fb_qos;
        end else begin
          res_status = qft_pkg::ST_NOT_FOUND;
        end
      end
      qft_pkg::OP_INSERT: begin
        if (last.exact_hit) begin
          wr.set_en = commit_go;
          wr.idx    = last.exact_idx;
        end else if (last.free_hit) begin
          wr.set_en = commit_go;
          wr.idx    = last.free_idx;
        end else begin
          res_status = qft_pkg::ST_FULL;
        end
      end
      qft_pkg::OP_REMOVE: begin
        if (last.exact_hit) begin
          wr.clr_en = commit_go;
          wr.idx    = last.exact_idx;
        end else begin
          res_status = qft_pkg::ST_NOT_FOUND;
        end
      end
      qft_pkg::OP_CLEAR: begin
        wr.clr_all = commit_go;
      end
      default: res_status = qft_pkg::ST_OK;
    endcase
  end

  always_comb begin
    out_valid_nxt  = out_valid_r;
    out_hit_nxt    = out_hit_r;
    out_port_nxt   = out_port_r;
    out_qos_nxt    = out_qos_r;
    out_status_nxt = out_status_r;
    if (commit_go) begin
      out_valid_nxt  = 1'b1;
      out_hit_nxt    = res_hit;
      out_port_nxt   = res_port;
      out_qos_nxt    = res_qos;
      out_status_nxt = res_status;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= qft_pkg::S_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      op_r         <= qft_pkg::op_t'(in_operation);
      query_r.addr <= in_dst_address[qft_pkg::KEY_W-1:0];
      query_r.qos  <= in_qos_class;
      port_r       <= in_port_in[qft_pkg::PORT_W-1:0];
    end
    out_hit_r    <= out_hit_nxt;
    out_port_r   <= out_port_nxt;
    out_qos_r    <= out_qos_nxt;
    out_status_r <= out_status_nxt;
  end

  assign in_ready        = (state_r == qft_pkg::S_IDLE);
  assign out_valid       = out_valid_r;
  assign out_hit         = out_hit_r;
  assign out_port_out    = qft_pkg::IN_PORT_W'(out_port_r);
  assign out_matched_qos = out_qos_r;
  assign out_status      = out_status_r;

endmodule
`default_nettype wire

>>> hw/rtl/qft_cell.sv
`default_nettype none
module qft_cell (
  input  wire                          clk,
  input  wire                          rst_n,
  input  wire  [qft_pkg::IDX_W-1:0]    cell_idx,
  input  qft_pkg::query_t              query,
  input  qft_pkg::wr_cmd_t             wr,
  input  qft_pkg::carry_t              carry_in,
  output qft_pkg::carry_t              carry_out
);

  logic                         valid_r;
  logic [qft_pkg::KEY_W-1:0]    addr_r;
  logic [qft_pkg::QOS_W-1:0]    qos_r;
  logic [qft_pkg::PORT_W-1:0]   port_r;
  qft_pkg::carry_t              carry_r;
  qft_pkg::carry_t              carry_nxt;
  logic                         sel;
  logic                         addr_match;
  logic                         exact;

  assign sel        = (wr.idx == cell_idx);
  assign addr_match = valid_r && (addr_r == query.addr);
  assign exact      = addr_match && (qos_r == query.qos);

  always_comb begin
    carry_nxt = carry_in;
    if (exact && !carry_in.exact_hit) begin
      carry_nxt.exact_hit  = 1'b1;
      carry_nxt.exact_idx  = cell_idx;
      carry_nxt.exact_port = port_r;
    end
    // Strict compare keeps the lowest-numbered slot among equal classes.
    if (addr_match && (!carry_in.fb_hit || (qos_r < carry_in.fb_qos))) begin
      carry_nxt.fb_hit  = 1'b1;
      carry_nxt.fb_qos  = qos_r;
      carry_nxt.fb_port = port_r;
    end
    if (!valid_r && !carry_in.free_hit) begin
      carry_nxt.free_hit = 1'b1;
      carry_nxt.free_idx = cell_idx;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (wr.clr_all) begin
      valid_r <= 1'b0;
    end else if (sel && wr.set_en) begin
      valid_r <= 1'b1;
    end else if (sel && wr.clr_en) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (sel && wr.set_en) begin
      addr_r <= wr.addr;
      qos_r  <= wr.qos;
      port_r <= wr.port;
    end
    carry_r <= carry_nxt;
  end

  assign carry_out = carry_r;

endmodule
`default_nettype wire
